### hw/rtl/ordered_array_insert_delete_search_top_defines.svh
// assertion helpers for the rtl, used by oaids_ctrl
`ifndef ORDERED_ARRAY_INSERT_DELETE_SEARCH_TOP_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_DELETE_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define OAIDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define OAIDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/oaids_pkg.sv
`default_nettype none

package oaids_pkg;

  localparam int CAPACITY_DEF = 128;

  // command codes
  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_SEARCH = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_INVALID  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  // broadcast control for the row of cells
  typedef struct packed {
    logic ins;   // shift right from position, load value at position
    logic del;   // shift left from position
    logic scan;  // advance the result chain one cell
    logic find;  // scan selects matching words, else the word at position
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/oaids_cell.sv
`default_nettype none

module oaids_cell #(
  parameter int IW = 7,
  parameter int CW = 8
) (
  input  logic                    clk,
  input  oaids_pkg::cell_ctl_t    ctl,
  input  logic [IW-1:0]           slot,
  input  logic [IW-1:0]           pos,
  input  logic [CW-1:0]           elem_count,
  input  logic signed [31:0]      val,
  input  logic signed [31:0]      left_word,
  input  logic signed [31:0]      right_word,
  output logic signed [31:0]      word,
  input  logic                    up_hit,
  input  logic signed [31:0]      up_word,
  input  logic [IW-1:0]           up_idx,
  output logic                    hit,
  output logic signed [31:0]      res_word,
  output logic [IW-1:0]           res_idx
);
  import oaids_pkg::*;

  logic sel;

  // this cell claims the result: a matching word below the count, or the addressed slot
  always_comb begin
    if (ctl.find) begin
      sel = (CW'(slot) < elem_count) && (word == val);
    end else begin
      sel = (slot == pos);
    end
  end

  // stored word: shift in from a neighbor or take the new value
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (slot > pos) begin
        word <= left_word;
      end else if (slot == pos) begin
        word <= val;
      end
    end else if (ctl.del) begin
      if (slot >= pos) begin
        word <= right_word;
      end
    end
  end

  // result chain moves toward slot zero, lower slots override
  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      hit      <= sel | up_hit;
      res_word <= sel ? word : up_word;
      res_idx  <= sel ? slot : up_idx;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/oaids_ctrl.sv
`default_nettype none

`include "ordered_array_insert_delete_search_top_defines.svh"

module oaids_ctrl #(
  parameter int CAPACITY = oaids_pkg::CAPACITY_DEF,
  parameter int IW = 7,
  parameter int CW = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              cmd,
  input  logic [7:0]              position,
  input  logic signed [31:0]      value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              status,
  output logic signed [31:0]      data,
  output logic [6:0]              found_index,
  output logic [7:0]              count,
  output oaids_pkg::cell_ctl_t    ctl,
  output logic [IW-1:0]           cell_pos,
  output logic signed [31:0]      cell_val,
  output logic [CW-1:0]           elem_count,
  input  logic                    res_hit,
  input  logic signed [31:0]      res_word,
  input  logic [IW-1:0]           res_idx
);
  import oaids_pkg::*;

  localparam int LW = (CW > 8) ? CW : 8;

  state_t             state, state_next;
  logic [CW-1:0]      elem_count_next;
  logic [IW-1:0]      scan_cnt;
  logic [2:0]         cmd_q;
  logic [IW-1:0]      pos_q;
  logic signed [31:0] val_q;
  logic               accept;
  logic               out_free;
  logic               load_out;
  status_t            st_next;
  logic signed [31:0] data_next;
  logic [IW-1:0]      idx_next;
  logic [LW-1:0]      pos_ext;
  logic [LW-1:0]      cnt_ext;
  logic               full;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign pos_ext  = LW'(position);
  assign cnt_ext  = LW'(elem_count);
  assign full     = (elem_count >= CW'(CAPACITY));

  // command decode, cell control and result selection
  always_comb begin
    state_next      = state;
    elem_count_next = elem_count;
    ctl             = '0;
    cell_pos        = pos_q;
    cell_val        = val_q;
    load_out        = 1'b0;
    st_next         = ST_OK;
    data_next       = '0;
    idx_next        = '0;
    case (state)
      S_IDLE: begin
        cell_pos = IW'(position);
        cell_val = value;
        if (accept) begin
          load_out = 1'b1;
          case (cmd)
            CMD_CLEAR: begin
              elem_count_next = '0;
            end
            CMD_APPEND: begin
              if (full) begin
                st_next = ST_FULL;
              end else begin
                ctl.ins         = 1'b1;
                cell_pos        = IW'(elem_count);
                elem_count_next = elem_count + 1'b1;
              end
            end
            CMD_INSERT: begin
              if (elem_count == '0) begin
                st_next = ST_EMPTY;
              end else if (pos_ext > cnt_ext) begin
                st_next = ST_INVALID;
              end else if (full) begin
                st_next = ST_FULL;
              end else begin
                ctl.ins         = 1'b1;
                elem_count_next = elem_count + 1'b1;
              end
            end
            CMD_DELETE, CMD_READ: begin
              if (elem_count == '0) begin
                st_next = ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                st_next = ST_INVALID;
              end else begin
                load_out   = 1'b0;
                state_next = S_SCAN;
              end
            end
            CMD_SEARCH: begin
              if (elem_count == '0) begin
                st_next = ST_EMPTY;
              end else begin
                load_out   = 1'b0;
                state_next = S_SCAN;
              end
            end
            default: begin
              st_next = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        ctl.find = (cmd_q == CMD_SEARCH);
        if (scan_cnt == IW'(CAPACITY - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          if (cmd_q == CMD_SEARCH) begin
            if (res_hit) begin
              idx_next = res_idx;
            end else begin
              st_next = ST_NOTFOUND;
            end
          end else begin
            data_next = res_word;
            if (cmd_q == CMD_DELETE) begin
              ctl.del         = 1'b1;
              elem_count_next = elem_count - 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      elem_count <= '0;
      scan_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      elem_count <= elem_count_next;
      scan_cnt   <= (state == S_SCAN) ? scan_cnt + 1'b1 : '0;
      out_valid  <= load_out || (out_valid && out_stall);
    end
  end

  // held command fields for the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      pos_q <= IW'(position);
      val_q <= value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= st_next;
      data        <= data_next;
      found_index <= 7'(idx_next);
      count       <= 8'(elem_count_next);
    end
  end

  `OAIDS_ASSERT_NOW(a_count_bound, 1'b1, elem_count <= CW'(CAPACITY), "count above capacity")
  `OAIDS_ASSERT_NOW(a_load_free, load_out, out_free, "result overwrites a waiting transfer")
  `OAIDS_ASSERT_NOW(a_read_hit, (state == S_FIN) && (cmd_q != CMD_SEARCH), res_hit, "addressed slot missed")
  `OAIDS_ASSERT_NEXT(a_ins_count, ctl.ins, elem_count == CW'($past(elem_count) + 1'b1), "insert count")
  `OAIDS_ASSERT_NEXT(a_del_count, ctl.del, elem_count == CW'($past(elem_count) - 1'b1), "delete count")

endmodule

`default_nettype wire

### hw/rtl/ordered_array_insert_delete_search_top.sv
// Ordered array of signed 32-bit words held in a row of cells, one word per cell.
// Input channel (in_valid/in_stall) carries cmd, position and value; output channel
// (out_valid/out_stall) returns status, data, found_index and count, one result per
// input transfer, in order.
// Clear, append, insert, unused codes and every error case: the result is in the
// output register in the cycle after the input transfer, and a new transfer can
// follow in the next cycle, so these run at one per cycle while out_stall is low.
// Delete, read and search (on a non-empty array, valid position): the transfer
// starts S_SCAN, where the answer travels down a registered result chain one cell
// per cycle toward cell zero; S_FIN then registers the result once the output is
// free, and delete shifts the upper words left in the cycle the result is registered.
// Insert and append shift all upper words right in the cycle of the transfer.
// in_stall is high while a delete, read or search is in progress and while a result
// waits in the output register under out_stall; the result then holds steady.
// Reset (rst, synchronous) empties the array and drops out_valid; stored words are
// not cleared and are never visible since only words below the count are read.
`default_nettype none

module ordered_array_insert_delete_search_top #(
  parameter int CAPACITY = oaids_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] data,
  output logic [6:0]         found_index,
  output logic [7:0]         count
);
  import oaids_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  cell_ctl_t          ctl;
  logic [IW-1:0]      cell_pos;
  logic signed [31:0] cell_val;
  logic [CW-1:0]      elem_count;

  logic signed [31:0] words    [CAPACITY];
  logic               hits     [CAPACITY];
  logic signed [31:0] res_words[CAPACITY];
  logic [IW-1:0]      res_idxs [CAPACITY];

  // sequencer and output register
  oaids_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .data        (data),
    .found_index (found_index),
    .count       (count),
    .ctl         (ctl),
    .cell_pos    (cell_pos),
    .cell_val    (cell_val),
    .elem_count  (elem_count),
    .res_hit     (hits[0]),
    .res_word    (res_words[0]),
    .res_idx     (res_idxs[0])
  );

  // row of cells, neighbors wired for shifting and the result chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_w;
    logic signed [31:0] right_w;
    logic               up_hit;
    logic signed [31:0] up_word;
    logic [IW-1:0]      up_idx;

    if (i == 0) begin : g_first
      assign left_w = words[i];
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = words[i];
      assign up_hit  = 1'b0;
      assign up_word = '0;
      assign up_idx  = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
      assign up_hit  = hits[i+1];
      assign up_word = res_words[i+1];
      assign up_idx  = res_idxs[i+1];
    end

    oaids_cell #(
      .IW (IW),
      .CW (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .slot       (IW'(i)),
      .pos        (cell_pos),
      .elem_count (elem_count),
      .val        (cell_val),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i]),
      .up_hit     (up_hit),
      .up_word    (up_word),
      .up_idx     (up_idx),
      .hit        (hits[i]),
      .res_word   (res_words[i]),
      .res_idx    (res_idxs[i])
    );
  end

endmodule

`default_nettype wire
